@@ rtl/wavhp_pkg.sv @@
// Shared types, constants and tag tables for the WAV header parser.
package wavhp_pkg;

  localparam int unsigned HeaderBytes = 44;
  localparam int unsigned PosWidth    = 6;

  localparam logic [PosWidth-1:0] POS_IDLE = PosWidth'(HeaderBytes);
  localparam logic [PosWidth-1:0] POS_LAST = PosWidth'(HeaderBytes - 1);

  localparam logic [31:0] FMT_CHUNK_PCM = 32'd16;
  localparam logic [15:0] AUDIO_FMT_PCM = 16'd1;
  localparam logic [15:0] CHANNELS_MONO = 16'd1;
  localparam logic [15:0] CHANNELS_STEREO = 16'd2;
  localparam logic [15:0] BITS_8  = 16'd8;
  localparam logic [15:0] BITS_16 = 16'd16;

  typedef enum logic [3:0] {
    STATUS_OK        = 4'd0,
    STATUS_RIFF_TAG  = 4'd1,
    STATUS_WAVE_TAG  = 4'd2,
    STATUS_FMT_TAG   = 4'd3,
    STATUS_FMT_SIZE  = 4'd4,
    STATUS_FORMAT    = 4'd5,
    STATUS_CHANNELS  = 4'd6,
    STATUS_BITS      = 4'd7,
    STATUS_DATA_TAG  = 4'd8
  } wavhp_status_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       start_of_header;
  } wavhp_byte_t;

  typedef struct packed {
    logic [31:0]   riff_size;
    logic [31:0]   fmt_chunk_size;
    logic [15:0]   audio_format;
    logic [15:0]   channel_count;
    logic [31:0]   sample_freq;
    logic [31:0]   byte_rate;
    logic [15:0]   block_align;
    logic [15:0]   bits_per_sample;
    logic [31:0]   data_size;
    wavhp_status_t status;
  } wavhp_result_t;

  // Expected character at a tag position; other positions return zero.
  function automatic logic [7:0] tag_char(logic [PosWidth-1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    unique case (pos)
      6'd0:    ch = "R";
      6'd1:    ch = "I";
      6'd2:    ch = "F";
      6'd3:    ch = "F";
      6'd8:    ch = "W";
      6'd9:    ch = "A";
      6'd10:   ch = "V";
      6'd11:   ch = "E";
      6'd12:   ch = "f";
      6'd13:   ch = "m";
      6'd14:   ch = "t";
      6'd15:   ch = " ";
      6'd36:   ch = "d";
      6'd37:   ch = "a";
      6'd38:   ch = "t";
      6'd39:   ch = "a";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/wavhp_if.sv @@
// Valid/ready channel interfaces for header bytes and parsed results.
interface wavhp_byte_if
  import wavhp_pkg::*;
();
  logic        valid;
  logic        ready;
  wavhp_byte_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface wavhp_result_if
  import wavhp_pkg::*;
();
  logic          valid;
  logic          ready;
  wavhp_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/wav_header_parser_core.sv @@
// Canonical PCM WAV header parser: byte stream in, one parsed header out.
//
// Takes one header byte per cycle on hdr; a byte flagged start_of_header
// restarts parsing at byte 0 and clears all gathered fields. Bytes arriving
// after the 44th and before the next start are dropped. Each byte is checked
// and shifted into the field registers in the cycle it transfers, and the
// 44th byte loads the output register, so the result is offered on res the
// cycle after that byte. Sustained rate is one byte per cycle; hdr only
// stalls while a finished result sits unclaimed in the output register.
// status holds the first error in stream order (0 when the header is good).
module wav_header_parser_core
  import wavhp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  wavhp_byte_if.sink            hdr,
  wavhp_result_if.source        res
);

  logic [PosWidth-1:0] position, position_next;
  logic [31:0]   riff_size,      riff_size_next;
  logic [31:0]   fmt_size,       fmt_size_next;
  logic [15:0]   audio_format,   audio_format_next;
  logic [15:0]   channels,       channels_next;
  logic [31:0]   sample_freq,    sample_freq_next;
  logic [31:0]   byte_rate,      byte_rate_next;
  logic [15:0]   block_align,    block_align_next;
  logic [15:0]   bits,           bits_next;
  logic [31:0]   data_size,      data_size_next;
  wavhp_status_t first_error,    first_error_next;

  logic          res_valid;
  wavhp_result_t res_data;

  logic                transfer;
  logic [PosWidth-1:0] pos;
  logic [7:0]          b;
  logic [1:0]          lane4;
  logic                lane2;
  wavhp_status_t       code;
  logic                emit;

  assign hdr.ready = !res_valid || res.ready;
  assign transfer  = hdr.valid && hdr.ready;
  assign b         = hdr.data.header_byte;
  assign pos       = hdr.data.start_of_header ? '0 : position;
  assign lane4     = pos[1:0];
  assign lane2     = pos[0];
  assign emit      = transfer && (pos == POS_LAST);

  always_comb begin
    riff_size_next    = riff_size;
    fmt_size_next     = fmt_size;
    audio_format_next = audio_format;
    channels_next     = channels;
    sample_freq_next  = sample_freq;
    byte_rate_next    = byte_rate;
    block_align_next  = block_align;
    bits_next         = bits;
    data_size_next    = data_size;
    first_error_next  = first_error;
    position_next     = position;
    code              = STATUS_OK;

    if (transfer && hdr.data.start_of_header) begin
      riff_size_next    = '0;
      fmt_size_next     = '0;
      audio_format_next = '0;
      channels_next     = '0;
      sample_freq_next  = '0;
      byte_rate_next    = '0;
      block_align_next  = '0;
      bits_next         = '0;
      data_size_next    = '0;
      first_error_next  = STATUS_OK;
      position_next     = '0;
    end

    if (transfer && pos < POS_IDLE) begin
      priority if (pos < 6'd4) begin
        if (b != tag_char(pos)) code = STATUS_RIFF_TAG;
      end else if (pos < 6'd8) begin
        riff_size_next[8*lane4 +: 8] = b;
      end else if (pos < 6'd12) begin
        if (b != tag_char(pos)) code = STATUS_WAVE_TAG;
      end else if (pos < 6'd16) begin
        if (b != tag_char(pos)) code = STATUS_FMT_TAG;
      end else if (pos < 6'd20) begin
        fmt_size_next[8*lane4 +: 8] = b;
        if (pos == 6'd19 && fmt_size_next != FMT_CHUNK_PCM) code = STATUS_FMT_SIZE;
      end else if (pos < 6'd22) begin
        audio_format_next[8*lane2 +: 8] = b;
        if (pos == 6'd21 && audio_format_next != AUDIO_FMT_PCM) code = STATUS_FORMAT;
      end else if (pos < 6'd24) begin
        channels_next[8*lane2 +: 8] = b;
        if (pos == 6'd23 && channels_next != CHANNELS_MONO &&
            channels_next != CHANNELS_STEREO) code = STATUS_CHANNELS;
      end else if (pos < 6'd28) begin
        sample_freq_next[8*lane4 +: 8] = b;
      end else if (pos < 6'd32) begin
        byte_rate_next[8*lane4 +: 8] = b;
      end else if (pos < 6'd34) begin
        block_align_next[8*lane2 +: 8] = b;
      end else if (pos < 6'd36) begin
        bits_next[8*lane2 +: 8] = b;
        if (pos == 6'd35 && bits_next != BITS_8 && bits_next != BITS_16) code = STATUS_BITS;
      end else if (pos < 6'd40) begin
        if (b != tag_char(pos)) code = STATUS_DATA_TAG;
      end else begin
        data_size_next[8*lane4 +: 8] = b;
      end

      // keep only the first error of the header
      if (first_error_next == STATUS_OK) first_error_next = code;
      position_next = pos + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position     <= POS_IDLE;
      riff_size    <= '0;
      fmt_size     <= '0;
      audio_format <= '0;
      channels     <= '0;
      sample_freq  <= '0;
      byte_rate    <= '0;
      block_align  <= '0;
      bits         <= '0;
      data_size    <= '0;
      first_error  <= STATUS_OK;
    end else begin
      position     <= position_next;
      riff_size    <= riff_size_next;
      fmt_size     <= fmt_size_next;
      audio_format <= audio_format_next;
      channels     <= channels_next;
      sample_freq  <= sample_freq_next;
      byte_rate    <= byte_rate_next;
      block_align  <= block_align_next;
      bits         <= bits_next;
      data_size    <= data_size_next;
      first_error  <= first_error_next;
    end
  end

  // Output register: load on the last header byte, hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_data.riff_size       <= riff_size_next;
      res_data.fmt_chunk_size  <= fmt_size_next;
      res_data.audio_format    <= audio_format_next;
      res_data.channel_count   <= channels_next;
      res_data.sample_freq     <= sample_freq_next;
      res_data.byte_rate       <= byte_rate_next;
      res_data.block_align     <= block_align_next;
      res_data.bits_per_sample <= bits_next;
      res_data.data_size       <= data_size_next;
      res_data.status          <= first_error_next;
    end
  end

  assign res.valid = res_valid;
  assign res.data  = res_data;

endmodule
